// ----- rtl/pmom_pkg.sv -----
package pmom_pkg;

  // Field widths
  localparam int SCALE_W = 32;
  localparam int THETA_W = 18;
  localparam int PHI_W   = 19;
  localparam int CURV_W  = 32;
  localparam int MASS_W  = 24;
  localparam int STAT_W  = 2;

  // Internal datapath widths
  localparam int ANG_W  = 35;              // Q.30 angle with guard bits
  localparam int XY_W   = 34;              // Q.30 rotation vector
  localparam int TRIG_W = 24;              // Q.20 cos/sin, signed
  localparam int TMAG_W = 22;              // magnitude of a Q.20 trig value
  localparam int PT_W   = SCALE_W + 8;     // pt quotient
  localparam int NUM_W  = PT_W + TMAG_W;   // pt times trig magnitude
  localparam int MX_W   = NUM_W - 20;      // product back in MeV Q.8
  localparam int SQ_W   = 128;             // sum of squares
  localparam int ROOT_W = 64;              // square root

  localparam logic signed [ANG_W-1:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [XY_W-1:0]  Q30_GAIN    = 34'sd652032874;

  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_SAT       = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_ZERO_CURV = 2'd2;

  // Side data riding along the pt divider
  typedef struct packed {
    logic [TMAG_W-1:0] cp_mag;
    logic [TMAG_W-1:0] sp_mag;
    logic [TMAG_W-1:0] ct_mag;
    logic [TMAG_W-1:0] st_mag;
    logic              cp_neg;
    logic              sp_neg;
    logic              ct_neg;
    logic              st_neg;
    logic              cz;
    logic [MASS_W-1:0] mass;
  } side_b_t;

  // Side data riding along the pz divider
  typedef struct packed {
    logic [MX_W-1:0]   mx;
    logic [MX_W-1:0]   my;
    logic [PT_W-1:0]   pt;
    logic [MASS_W-1:0] mass;
    logic              cp_neg;
    logic              sp_neg;
    logic              ct_neg;
    logic              st_neg;
    logic              cp_zero;
    logic              sp_zero;
    logic              ct_zero;
    logic              cz;
    logic              pz_inf;
  } side_d_t;

  // Side data riding along the square root
  typedef struct packed {
    logic [MX_W-1:0]  mx;
    logic [MX_W-1:0]  my;
    logic [NUM_W-1:0] pz;
    logic             cp_neg;
    logic             sp_neg;
    logic             ct_neg;
    logic             st_neg;
    logic             cp_zero;
    logic             sp_zero;
    logic             ct_zero;
    logic             cz;
    logic             pz_inf;
  } side_e_t;

  // Arctangent of 2^-idx in Q.30, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned idx);
    logic signed [ANG_W-1:0] r;
    case (idx)
      0:  r = 35'sd843314857;
      1:  r = 35'sd497837829;
      2:  r = 35'sd263043837;
      3:  r = 35'sd133525159;
      4:  r = 35'sd67021687;
      5:  r = 35'sd33543516;
      6:  r = 35'sd16775851;
      7:  r = 35'sd8388437;
      8:  r = 35'sd4194283;
      9:  r = 35'sd2097149;
      10: r = 35'sd1048576;
      11: r = 35'sd524288;
      12: r = 35'sd262144;
      13: r = 35'sd131072;
      14: r = 35'sd65536;
      15: r = 35'sd32768;
      16: r = 35'sd16384;
      17: r = 35'sd8192;
      18: r = 35'sd4096;
      19: r = 35'sd2048;
      20: r = 35'sd1024;
      21: r = 35'sd512;
      22: r = 35'sd256;
      23: r = 35'sd128;
      24: r = 35'sd64;
      25: r = 35'sd32;
      26: r = 35'sd16;
      27: r = 35'sd8;
      28: r = 35'sd4;
      29: r = 35'sd2;
      30: r = 35'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Magnitude of a Q.20 trig value
  function automatic logic [TMAG_W-1:0] abs_trig(input logic signed [TRIG_W-1:0] t);
    logic [TRIG_W-1:0] a;
    a = t[TRIG_W-1] ? (~t + 1'b1) : t;
    return a[TMAG_W-1:0];
  endfunction

endpackage

// ----- rtl/pmom_track_if.sv -----
interface pmom_track_if;
  logic                             valid;
  logic                             ready;
  logic [pmom_pkg::THETA_W-1:0]     theta_angle;
  logic signed [pmom_pkg::PHI_W-1:0] phi_angle;
  logic signed [pmom_pkg::CURV_W-1:0] curvature;
  logic [pmom_pkg::MASS_W-1:0]      particle_mass;

  modport source (output valid, theta_angle, phi_angle, curvature, particle_mass,
                  input ready);
  modport sink (input valid, theta_angle, phi_angle, curvature, particle_mass,
                output ready);
endinterface

// ----- rtl/pmom_result_if.sv -----
interface pmom_result_if #(
  parameter int MOMENTUM_WIDTH = 48
);
  logic                             valid;
  logic                             ready;
  logic signed [MOMENTUM_WIDTH-1:0] mom_x;
  logic signed [MOMENTUM_WIDTH-1:0] mom_y;
  logic signed [MOMENTUM_WIDTH-1:0] mom_z;
  logic [MOMENTUM_WIDTH-2:0]        energy;
  logic [pmom_pkg::STAT_W-1:0]      status;

  modport source (output valid, mom_x, mom_y, mom_z, energy, status, input ready);
  modport sink (input valid, mom_x, mom_y, mom_z, energy, status, output ready);
endinterface

// ----- rtl/pmom_cordic.sv -----
module pmom_cordic #(
  parameter int STAGES = 20,
  parameter int SIDE_W = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [pmom_pkg::ANG_W-1:0] in_angle,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  output logic signed [pmom_pkg::TRIG_W-1:0] out_cos,
  output logic signed [pmom_pkg::TRIG_W-1:0] out_sin,
  output logic [SIDE_W-1:0]                 out_side
);
  import pmom_pkg::*;

  logic                    pre_v;
  logic signed [ANG_W-1:0] pre_z;
  logic                    pre_flip;
  logic [SIDE_W-1:0]       pre_side;

  logic                    st_v    [STAGES];
  logic signed [XY_W-1:0]  st_x    [STAGES];
  logic signed [XY_W-1:0]  st_y    [STAGES];
  logic signed [ANG_W-1:0] st_z    [STAGES];
  logic                    st_flip [STAGES];
  logic [SIDE_W-1:0]       st_side [STAGES];

  logic signed [XY_W-1:0]  fx;
  logic signed [XY_W-1:0]  fy;

  // Fold the angle into +-pi/2, remember to negate at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      pre_v <= 1'b0;
    end else if (en) begin
      pre_v <= in_valid;
    end
    if (en) begin
      pre_side <= in_side;
      if (in_angle > Q30_HALF_PI) begin
        pre_z    <= in_angle - Q30_PI;
        pre_flip <= 1'b1;
      end else if (in_angle < -Q30_HALF_PI) begin
        pre_z    <= in_angle + Q30_PI;
        pre_flip <= 1'b1;
      end else begin
        pre_z    <= in_angle;
        pre_flip <= 1'b0;
      end
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic                    v_i;
    logic signed [XY_W-1:0]  x_i;
    logic signed [XY_W-1:0]  y_i;
    logic signed [ANG_W-1:0] z_i;
    logic                    f_i;
    logic [SIDE_W-1:0]       s_i;
    logic signed [XY_W-1:0]  dx;
    logic signed [XY_W-1:0]  dy;

    if (i == 0) begin : g_first
      assign v_i = pre_v;
      assign x_i = Q30_GAIN;
      assign y_i = '0;
      assign z_i = pre_z;
      assign f_i = pre_flip;
      assign s_i = pre_side;
    end else begin : g_next
      assign v_i = st_v[i-1];
      assign x_i = st_x[i-1];
      assign y_i = st_y[i-1];
      assign z_i = st_z[i-1];
      assign f_i = st_flip[i-1];
      assign s_i = st_side[i-1];
    end

    assign dx = y_i >>> i;
    assign dy = x_i >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[i] <= 1'b0;
      end else if (en) begin
        st_v[i] <= v_i;
      end
      if (en) begin
        st_flip[i] <= f_i;
        st_side[i] <= s_i;
        if (z_i >= 0) begin
          st_x[i] <= x_i - dx;
          st_y[i] <= y_i + dy;
          st_z[i] <= z_i - atan_q30(i);
        end else begin
          st_x[i] <= x_i + dx;
          st_y[i] <= y_i - dy;
          st_z[i] <= z_i + atan_q30(i);
        end
      end
    end
  end

  // Undo the fold and floor to Q.20
  assign fx = st_flip[STAGES-1] ? -st_x[STAGES-1] : st_x[STAGES-1];
  assign fy = st_flip[STAGES-1] ? -st_y[STAGES-1] : st_y[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= st_v[STAGES-1];
    end
    if (en) begin
      out_cos  <= TRIG_W'(fx >>> 10);
      out_sin  <= TRIG_W'(fy >>> 10);
      out_side <= st_side[STAGES-1];
    end
  end

endmodule

// ----- rtl/pmom_div.sv -----
module pmom_div #(
  parameter int N_W    = 40,
  parameter int D_W    = 32,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [N_W-1:0]    in_num,
  input  logic [D_W-1:0]    in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [N_W-1:0]    out_quot,
  output logic [SIDE_W-1:0] out_side
);

  logic              st_v    [N_W];
  logic [D_W-1:0]    st_rem  [N_W];
  logic [N_W-1:0]    st_num  [N_W];
  logic [N_W-1:0]    st_q    [N_W];
  logic [D_W-1:0]    st_den  [N_W];
  logic [SIDE_W-1:0] st_side [N_W];

  // Restoring division, one quotient bit per stage
  for (genvar k = 0; k < N_W; k++) begin : g_stage
    logic              v_i;
    logic [D_W-1:0]    r_i;
    logic [N_W-1:0]    n_i;
    logic [N_W-1:0]    q_i;
    logic [D_W-1:0]    d_i;
    logic [SIDE_W-1:0] s_i;
    logic [D_W:0]      trial;
    logic [D_W:0]      diff;
    logic              take;

    if (k == 0) begin : g_first
      assign v_i = in_valid;
      assign r_i = '0;
      assign n_i = in_num;
      assign q_i = '0;
      assign d_i = in_den;
      assign s_i = in_side;
    end else begin : g_next
      assign v_i = st_v[k-1];
      assign r_i = st_rem[k-1];
      assign n_i = st_num[k-1];
      assign q_i = st_q[k-1];
      assign d_i = st_den[k-1];
      assign s_i = st_side[k-1];
    end

    assign trial = {r_i, n_i[N_W-1]};
    assign diff  = trial - {1'b0, d_i};
    assign take  = (trial >= {1'b0, d_i});

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k] <= 1'b0;
      end else if (en) begin
        st_v[k] <= v_i;
      end
      if (en) begin
        st_rem[k]  <= take ? diff[D_W-1:0] : trial[D_W-1:0];
        st_num[k]  <= n_i << 1;
        st_q[k]    <= {q_i[N_W-2:0], take};
        st_den[k]  <= d_i;
        st_side[k] <= s_i;
      end
    end
  end

  assign out_valid = st_v[N_W-1];
  assign out_quot  = st_q[N_W-1];
  assign out_side  = st_side[N_W-1];

endmodule

// ----- rtl/perigee_to_four_momentum_top.sv -----
// Perigee to four-momentum converter. Takes theta, phi, signed curvature and a mass
// hypothesis and returns px, py, pz and energy in MeV with 8 fraction bits, with
// pt = (pt_scale << 8) / |curvature|. A new track word is taken every clock unless
// a finished result is held at the output. Behind the CORDIC the result passes the
// bit-per-stage pt divider (40 stages), pz divider (62 stages) and square root
// (64 stages). The whole pipeline holds while a finished result waits at the output.
// Status is 2 for zero curvature (momenta with a nonzero trig factor forced to the
// signed limit), 1 when any result saturated, else 0. Write pt_scale only while idle.
module perigee_to_four_momentum_top #(
  parameter int CORDIC_STAGES  = 20,
  parameter int MOMENTUM_WIDTH = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [pmom_pkg::SCALE_W-1:0] cfg_wr_data,
  pmom_track_if.sink                   track,
  pmom_result_if.source                result
);
  import pmom_pkg::*;

  localparam int MW = MOMENTUM_WIDTH;
  localparam logic [MW-1:0] LIM_MW = {1'b0, {(MW-1){1'b1}}};
  localparam logic [63:0]   LIMIT  = 64'(LIM_MW);

  logic [SCALE_W-1:0] pt_scale;
  logic               en;
  logic               res_v;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      pt_scale <= '0;
    end else if (cfg_wr_en) begin
      pt_scale <= cfg_wr_data;
    end
  end

  // Advance everything unless the output word is stuck
  assign en          = !res_v || result.ready;
  assign track.ready = en;

  // Input angle widening and curvature magnitude
  logic signed [ANG_W-1:0] z_phi;
  logic signed [ANG_W-1:0] z_theta;
  logic [CURV_W-1:0]       cmag_in;

  assign z_phi   = {{(ANG_W-PHI_W-14){track.phi_angle[PHI_W-1]}}, track.phi_angle, 14'b0};
  assign z_theta = {{(ANG_W-THETA_W-14){1'b0}}, track.theta_angle, 14'b0};
  assign cmag_in = track.curvature[CURV_W-1] ? (~track.curvature + 1'b1) : track.curvature;

  logic                     v_phi;
  logic                     v_th;
  logic signed [TRIG_W-1:0] cp;
  logic signed [TRIG_W-1:0] sp;
  logic signed [TRIG_W-1:0] ct;
  logic signed [TRIG_W-1:0] st;
  logic [CURV_W-1:0]        cmag_a;
  logic [MASS_W-1:0]        mass_a;

  pmom_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(CURV_W)) u_cordic_phi (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(track.valid), .in_angle(z_phi), .in_side(cmag_in),
    .out_valid(v_phi), .out_cos(cp), .out_sin(sp), .out_side(cmag_a)
  );

  pmom_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(MASS_W)) u_cordic_theta (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(track.valid), .in_angle(z_theta), .in_side(track.particle_mass),
    .out_valid(v_th), .out_cos(ct), .out_sin(st), .out_side(mass_a)
  );

  // pt divider
  side_b_t            sb_in;
  logic [PT_W-1:0]    pt_num;
  logic [CURV_W-1:0]  pt_den;
  logic               vb;
  logic [PT_W-1:0]    pt_b;
  logic [$bits(side_b_t)-1:0] sb_raw;
  side_b_t            sb;

  always_comb begin
    sb_in.cp_mag = abs_trig(cp);
    sb_in.sp_mag = abs_trig(sp);
    sb_in.ct_mag = abs_trig(ct);
    sb_in.st_mag = abs_trig(st);
    sb_in.cp_neg = cp[TRIG_W-1];
    sb_in.sp_neg = sp[TRIG_W-1];
    sb_in.ct_neg = ct[TRIG_W-1];
    sb_in.st_neg = st[TRIG_W-1];
    sb_in.cz     = (cmag_a == '0);
    sb_in.mass   = mass_a;
  end

  assign pt_num = {pt_scale, 8'b0};
  assign pt_den = (cmag_a == '0) ? CURV_W'(1) : cmag_a;

  pmom_div #(.N_W(PT_W), .D_W(CURV_W), .SIDE_W($bits(side_b_t))) u_div_pt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v_phi && v_th), .in_num(pt_num), .in_den(pt_den), .in_side(sb_in),
    .out_valid(vb), .out_quot(pt_b), .out_side(sb_raw)
  );
  assign sb = side_b_t'(sb_raw);

  // Scale the trig factors by pt
  logic             vc;
  logic [NUM_W-1:0] px_c;
  logic [NUM_W-1:0] py_c;
  logic [NUM_W-1:0] nz_c;
  logic [PT_W-1:0]  pt_c;
  side_b_t          sb_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
    if (en) begin
      px_c <= NUM_W'(pt_b) * NUM_W'(sb.cp_mag);
      py_c <= NUM_W'(pt_b) * NUM_W'(sb.sp_mag);
      nz_c <= NUM_W'(pt_b) * NUM_W'(sb.ct_mag);
      pt_c <= pt_b;
      sb_c <= sb;
    end
  end

  // pz divider
  side_d_t           sd_in;
  logic [TMAG_W-1:0] pz_den;
  logic              vd;
  logic [NUM_W-1:0]  pz_d;
  logic [$bits(side_d_t)-1:0] sd_raw;
  side_d_t           sd;

  always_comb begin
    sd_in.mx      = px_c[NUM_W-1:20];
    sd_in.my      = py_c[NUM_W-1:20];
    sd_in.pt      = pt_c;
    sd_in.mass    = sb_c.mass;
    sd_in.cp_neg  = sb_c.cp_neg;
    sd_in.sp_neg  = sb_c.sp_neg;
    sd_in.ct_neg  = sb_c.ct_neg;
    sd_in.st_neg  = sb_c.st_neg;
    sd_in.cp_zero = (sb_c.cp_mag == '0);
    sd_in.sp_zero = (sb_c.sp_mag == '0);
    sd_in.ct_zero = (sb_c.ct_mag == '0);
    sd_in.cz      = sb_c.cz;
    sd_in.pz_inf  = (nz_c != '0) && (sb_c.st_mag == '0);
  end

  assign pz_den = (sb_c.st_mag == '0) ? TMAG_W'(1) : sb_c.st_mag;

  pmom_div #(.N_W(NUM_W), .D_W(TMAG_W), .SIDE_W($bits(side_d_t))) u_div_pz (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vc), .in_num(nz_c), .in_den(pz_den), .in_side(sd_in),
    .out_valid(vd), .out_quot(pz_d), .out_side(sd_raw)
  );
  assign sd = side_d_t'(sd_raw);

  // Partial products of the squares
  logic        ve;
  logic [63:0] pt_ll;
  logic [39:0] pt_hl;
  logic [15:0] pt_hh;
  logic [63:0] pz_ll;
  logic [61:0] pz_hl;
  logic [59:0] pz_hh;
  logic [47:0] m2_e;
  side_e_t     se_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= vd;
    end
    if (en) begin
      pt_ll        <= 64'(sd.pt[31:0]) * 64'(sd.pt[31:0]);
      pt_hl        <= 40'(sd.pt[39:32]) * 40'(sd.pt[31:0]);
      pt_hh        <= 16'(sd.pt[39:32]) * 16'(sd.pt[39:32]);
      pz_ll        <= 64'(pz_d[31:0]) * 64'(pz_d[31:0]);
      pz_hl        <= 62'(pz_d[61:32]) * 62'(pz_d[31:0]);
      pz_hh        <= 60'(pz_d[61:32]) * 60'(pz_d[61:32]);
      m2_e         <= 48'(sd.mass) * 48'(sd.mass);
      se_e.mx      <= sd.mx;
      se_e.my      <= sd.my;
      se_e.pz      <= pz_d;
      se_e.cp_neg  <= sd.cp_neg;
      se_e.sp_neg  <= sd.sp_neg;
      se_e.ct_neg  <= sd.ct_neg;
      se_e.st_neg  <= sd.st_neg;
      se_e.cp_zero <= sd.cp_zero;
      se_e.sp_zero <= sd.sp_zero;
      se_e.ct_zero <= sd.ct_zero;
      se_e.cz      <= sd.cz;
      se_e.pz_inf  <= sd.pz_inf;
    end
  end

  // Combine partial products
  logic            vf;
  logic [SQ_W-1:0] pt2_f;
  logic [SQ_W-1:0] pz2_f;
  logic [47:0]     m2_f;
  side_e_t         se_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= ve;
    end
    if (en) begin
      pt2_f <= (SQ_W'(pt_hh) << 64) + (SQ_W'(pt_hl) << 33) + SQ_W'(pt_ll);
      pz2_f <= (SQ_W'(pz_hh) << 64) + (SQ_W'(pz_hl) << 33) + SQ_W'(pz_ll);
      m2_f  <= m2_e;
      se_f  <= se_e;
    end
  end

  // Sum of squares
  logic            vg;
  logic [SQ_W-1:0] n_g;
  side_e_t         se_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (en) begin
      vg <= vf;
    end
    if (en) begin
      n_g  <= pt2_f + pz2_f + SQ_W'(m2_f);
      se_g <= se_f;
    end
  end

  // Square root, one root bit per stage
  logic              sq_v    [ROOT_W];
  logic [SQ_W-1:0]   sq_n    [ROOT_W];
  logic [ROOT_W+1:0] sq_rem  [ROOT_W];
  logic [ROOT_W-1:0] sq_root [ROOT_W];
  side_e_t           sq_side [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic              v_i;
    logic [SQ_W-1:0]   n_i;
    logic [ROOT_W+1:0] rem_i;
    logic [ROOT_W-1:0] root_i;
    side_e_t           s_i;
    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;

    if (k == 0) begin : g_first
      assign v_i    = vg;
      assign n_i    = n_g;
      assign rem_i  = '0;
      assign root_i = '0;
      assign s_i    = se_g;
    end else begin : g_next
      assign v_i    = sq_v[k-1];
      assign n_i    = sq_n[k-1];
      assign rem_i  = sq_rem[k-1];
      assign root_i = sq_root[k-1];
      assign s_i    = sq_side[k-1];
    end

    assign rem_sh = {rem_i[ROOT_W-1:0], n_i[SQ_W-1 -: 2]};
    assign trial  = {root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k] <= 1'b0;
      end else if (en) begin
        sq_v[k] <= v_i;
      end
      if (en) begin
        sq_n[k]    <= n_i << 2;
        sq_side[k] <= s_i;
        if (rem_sh >= trial) begin
          sq_rem[k]  <= rem_sh - trial;
          sq_root[k] <= {root_i[ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem[k]  <= rem_sh;
          sq_root[k] <= {root_i[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // Saturate, sign and pick the status
  function automatic logic [MW-1:0] signed_out(input logic [63:0] mag, input logic neg);
    logic [MW-1:0] m;
    m = mag[MW-1:0];
    return neg ? (~m + 1'b1) : m;
  endfunction

  side_e_t       sh;
  logic [63:0]   mx64;
  logic [63:0]   my64;
  logic [63:0]   pz64;
  logic [63:0]   e64;
  logic          sat_x;
  logic          sat_y;
  logic          sat_z;
  logic          sat_e;
  logic          zneg;
  logic [MW-1:0] mom_x_next;
  logic [MW-1:0] mom_y_next;
  logic [MW-1:0] mom_z_next;
  logic [MW-2:0] energy_next;
  logic [STAT_W-1:0] status_next;

  assign sh = sq_side[ROOT_W-1];

  always_comb begin
    mx64  = 64'(sh.mx);
    my64  = 64'(sh.my);
    pz64  = 64'(sh.pz);
    e64   = 64'(sq_root[ROOT_W-1]);
    zneg  = sh.ct_neg ^ sh.st_neg;
    sat_x = mx64 > LIMIT;
    sat_y = my64 > LIMIT;
    sat_z = sh.pz_inf || (pz64 > LIMIT);
    sat_e = sh.pz_inf || (e64 > LIMIT);
    if (sh.cz) begin
      mom_x_next  = sh.cp_zero ? '0 : signed_out(LIMIT, sh.cp_neg);
      mom_y_next  = sh.sp_zero ? '0 : signed_out(LIMIT, sh.sp_neg);
      mom_z_next  = sh.ct_zero ? '0 : signed_out(LIMIT, zneg);
      energy_next = LIM_MW[MW-2:0];
      status_next = STATUS_ZERO_CURV;
    end else begin
      mom_x_next  = signed_out(sat_x ? LIMIT : mx64, sh.cp_neg);
      mom_y_next  = signed_out(sat_y ? LIMIT : my64, sh.sp_neg);
      if (sh.pz_inf) begin
        mom_z_next = signed_out(LIMIT, sh.ct_neg);
      end else begin
        mom_z_next = signed_out(sat_z ? LIMIT : pz64, zneg);
      end
      energy_next = sat_e ? LIM_MW[MW-2:0] : e64[MW-2:0];
      status_next = (sat_x || sat_y || sat_z || sat_e) ? STATUS_SAT : STATUS_OK;
    end
  end

  // Output word register
  logic [MW-1:0]     mom_x;
  logic [MW-1:0]     mom_y;
  logic [MW-1:0]     mom_z;
  logic [MW-2:0]     energy;
  logic [STAT_W-1:0] status;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (en) begin
      res_v <= sq_v[ROOT_W-1];
    end
    if (en) begin
      mom_x  <= mom_x_next;
      mom_y  <= mom_y_next;
      mom_z  <= mom_z_next;
      energy <= energy_next;
      status <= status_next;
    end
  end

  assign result.valid  = res_v;
  assign result.mom_x  = mom_x;
  assign result.mom_y  = mom_y;
  assign result.mom_z  = mom_z;
  assign result.energy = energy;
  assign result.status = status;

endmodule

// ----- rtl/pmom_checker.sv -----
module pmom_checker #(
  parameter int MW = 48
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [MW-2:0]                out_energy,
  input logic [pmom_pkg::STAT_W-1:0]  out_status
);
  import pmom_pkg::*;

  // Reset empties the output stage
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid right after reset");

  // Input holds off only behind a blocked output word
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  // A blocked output word stays offered
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output word dropped while stalled");

  // Zero curvature always reports saturated energy
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == STATUS_ZERO_CURV)) |-> (out_energy == {(MW-1){1'b1}}))
    else $error("zero curvature word without saturated energy");

endmodule

bind perigee_to_four_momentum_top pmom_checker #(.MW(MOMENTUM_WIDTH)) u_pmom_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(track.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .out_energy(result.energy),
  .out_status(result.status)
);

// ----- tb/sv/tb_perigee_to_four_momentum_top.sv -----
module tb_perigee_to_four_momentum_top;
  import pmom_pkg::*;

  localparam int STAGES    = 20;
  localparam int MW        = 48;
  localparam int LATENCY   = STAGES + 173;
  localparam int N_RANDOM  = 800;
  localparam longint unsigned LIMIT = (64'd1 << (MW - 1)) - 1;

  localparam longint Q30_PI_L   = 64'sd3373259426;
  localparam longint Q30_HALF_L = 64'sd1686629713;
  localparam longint Q30_GAIN_L = 64'sd652032874;

  typedef struct packed {
    logic [THETA_W-1:0]        theta;
    logic signed [PHI_W-1:0]   phi;
    logic signed [CURV_W-1:0]  curv;
    logic [MASS_W-1:0]         mass;
  } track_word_t;

  typedef struct packed {
    logic signed [MW-1:0] px;
    logic signed [MW-1:0] py;
    logic signed [MW-1:0] pz;
    logic [MW-2:0]        en;
    logic [STAT_W-1:0]    st;
  } momentum_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [SCALE_W-1:0] cfg_wr_data = '0;

  pmom_track_if track ();
  pmom_result_if #(.MOMENTUM_WIDTH(MW)) result ();

  perigee_to_four_momentum_top #(.CORDIC_STAGES(STAGES), .MOMENTUM_WIDTH(MW)) uut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .track(track.sink), .result(result.source)
  );

  track_word_t pending_tracks[$];
  momentum_t   expected_moms[$];
  logic [SCALE_W-1:0] scale_now = '0;
  int errors = 0;
  bit stall_req = 1'b0;
  bit drain_hold = 1'b0;
  int long_stall = 0;
  int burst_left = 0;
  int gap_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Floor-rounding arithmetic shift
  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  // Rotation-mode CORDIC, returns Q.20 cos and sin
  function automatic void rotate_angle(input longint z_in, output longint c20,
                                       output longint s20);
    longint x, y, z, dx, dy;
    longint atn;
    bit flip;
    x = Q30_GAIN_L; y = 0; z = z_in; flip = 0;
    if (z > Q30_HALF_L) begin
      z -= Q30_PI_L; flip = 1;
    end else if (z < -Q30_HALF_L) begin
      z += Q30_PI_L; flip = 1;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      atn = longint'(atan_q30(i));
      if (z >= 0) begin
        x -= dx; y += dy; z -= atn;
      end else begin
        x += dx; y -= dy; z += atn;
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c20 = fshift(x, 10);
    s20 = fshift(y, 10);
  endfunction

  function automatic logic [MW-1:0] signed_mag(longint unsigned mag, bit neg);
    return neg ? (MW'(0) - MW'(mag)) : MW'(mag);
  endfunction

  function automatic longint unsigned clamp(longint unsigned mag, ref bit sat);
    if (mag > LIMIT) begin
      sat = 1;
      return LIMIT;
    end
    return mag;
  endfunction

  function automatic longint unsigned root128(logic [127:0] n);
    logic [63:0] r, c;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic longint unsigned mag_of(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Compute the four-momentum for one track word
  function automatic momentum_t four_momentum(track_word_t w);
    momentum_t m;
    longint cp, sp, ct, st;
    longint unsigned cmag, pt, num, pz;
    logic [127:0] sq;
    bit sat, zneg;
    sat = 0; pz = 0;
    rotate_angle(longint'(w.phi) * 16384, cp, sp);
    rotate_angle(longint'({1'b0, w.theta}) * 16384, ct, st);
    cmag = w.curv[31] ? longint'(-longint'(w.curv)) : longint'(w.curv);
    zneg = (ct < 0) != (st < 0);
    if (cmag == 0) begin
      m.px = (cp == 0) ? '0 : signed_mag(LIMIT, cp < 0);
      m.py = (sp == 0) ? '0 : signed_mag(LIMIT, sp < 0);
      m.pz = (ct == 0) ? '0 : signed_mag(LIMIT, zneg);
      m.en = (MW-1)'(LIMIT);
      m.st = STATUS_ZERO_CURV;
      return m;
    end
    pt = ({32'd0, scale_now} << 8) / cmag;
    m.px = signed_mag(clamp((pt * mag_of(cp)) >> 20, sat), cp < 0);
    m.py = signed_mag(clamp((pt * mag_of(sp)) >> 20, sat), sp < 0);
    num = pt * mag_of(ct);
    if (num != 0 && st == 0) begin
      sat = 1;
      m.pz = signed_mag(LIMIT, ct < 0);
      m.en = (MW-1)'(LIMIT);
    end else begin
      if (num != 0) pz = num / mag_of(st);
      m.pz = signed_mag(clamp(pz, sat), zneg);
      sq = {64'd0, pt} * {64'd0, pt} + {64'd0, pz} * {64'd0, pz}
         + {64'd0, 40'd0, w.mass} * {64'd0, 40'd0, w.mass};
      m.en = (MW-1)'(clamp(root128(sq), sat));
    end
    m.st = sat ? STATUS_SAT : STATUS_OK;
    return m;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  // Drive track words in bursts with gaps
  always @(posedge clk) begin
    if (rst) begin
      track.valid <= 1'b0;
    end else begin
      if (track.valid && track.ready) begin
        expected_moms.push_back(four_momentum({track.theta_angle, track.phi_angle,
                                               track.curvature, track.particle_mass}));
      end
      if (!track.valid || track.ready) begin
        if (pending_tracks.size() > 0 && !drain_hold && gap_left == 0) begin
          track_word_t w;
          w = pending_tracks.pop_front();
          track.valid <= 1'b1;
          track.theta_angle <= w.theta;
          track.phi_angle <= w.phi;
          track.curvature <= w.curv;
          track.particle_mass <= w.mass;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
          end else begin
            burst_left--;
          end
        end else begin
          track.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // Check each accepted result word; stall on a pattern plus long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_moms.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          momentum_t e;
          e = expected_moms.pop_front();
          if (result.mom_x !== e.px) report_mismatch("mom_x", result.mom_x, e.px);
          if (result.mom_y !== e.py) report_mismatch("mom_y", result.mom_y, e.py);
          if (result.mom_z !== e.pz) report_mismatch("mom_z", result.mom_z, e.pz);
          if (result.energy !== e.en) report_mismatch("energy", result.energy, e.en);
          if (result.status !== e.st) report_mismatch("status", result.status, e.st);
        end
      end
      if (long_stall > 0) begin
        long_stall--;
        result.ready <= 1'b0;
      end else if (stall_req || $urandom_range(0, 999) == 0) begin
        stall_req = 1'b0;
        long_stall = 3 * LATENCY;
        result.ready <= 1'b0;
      end else begin
        case ($urandom_range(0, 3))
          0: result.ready <= ($urandom_range(0, 1) == 1);
          default: result.ready <= 1'b1;
        endcase
      end
    end
  end

  function automatic track_word_t rand_track(bit wild);
    track_word_t w;
    w.theta = wild ? THETA_W'($urandom) : THETA_W'($urandom_range(0, 205887));
    w.phi = wild ? PHI_W'($urandom) : PHI_W'(int'($urandom_range(0, 411774)) - 205887);
    case ($urandom_range(0, 9))
      0: w.curv = 0;
      1: w.curv = $urandom_range(0, 15) - 8;
      2: w.curv = $urandom;
      default: w.curv = 32'($urandom_range(1, 1 << 20)) * (($urandom_range(0, 1)) ? -1 : 1);
    endcase
    w.mass = ($urandom_range(0, 3) == 0) ? MASS_W'($urandom_range(0, 40000))
                                         : MASS_W'($urandom);
    return w;
  endfunction

  task automatic wait_idle();
    while (pending_tracks.size() > 0 || track.valid || expected_moms.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic set_scale(input logic [SCALE_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    scale_now = v;
    @(posedge clk);
  endtask

  // Fill the queue phase by phase, writing the scale between phases
  initial begin
    logic [SCALE_W-1:0] scales[5];
    track_word_t w;
    int n_phase;
    scales = '{32'd0, 32'hFFFF_FFFF, 32'd299792, 32'd1, 32'd150000000};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < 5; ph++) begin
      set_scale(scales[ph]);
      // one large phase that outruns the pipeline while the receiver holds off
      n_phase = (ph == 1) ? 2 * N_RANDOM / 5 : N_RANDOM / 5 - N_RANDOM / 20;
      if (ph == 1) begin
        stall_req = 1'b1;
      end
      if (ph == 2) begin
        // directed corners
        pending_tracks.push_back('{0, 0, 1, 0});
        pending_tracks.push_back('{205887, 205887, -1, 24'hFFFFFF});
        pending_tracks.push_back('{102944, -205887, 0, 100});
        pending_tracks.push_back('{0, 102944, 0, 0});
        pending_tracks.push_back('{18'h3FFFF, 19'sh3FFFF, 32'sh8000_0000, 24'hFFFFFF});
        pending_tracks.push_back('{0, 19'sh40000, 32'sh7FFF_FFFF, 1});
        pending_tracks.push_back('{102944, 102944, 1000, 35000});
        pending_tracks.push_back('{51472, -51472, -4096, 0});
        pending_tracks.push_back('{205887, 0, 0, 24'hFFFFFF});
        pending_tracks.push_back('{154415, 154415, 3, 12345});
      end
      for (int i = 0; i < n_phase; i++) begin
        w = rand_track($urandom_range(0, 7) == 0);
        pending_tracks.push_back(w);
      end
      if (ph == 3) begin
        // pause until the pipeline has fully drained
        while (pending_tracks.size() > 80) @(posedge clk);
        drain_hold = 1'b1;
        while (track.valid || expected_moms.size() > 0) @(posedge clk);
        drain_hold = 1'b0;
      end
      wait_idle();
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pmom_pkg.sv
rtl/pmom_track_if.sv
rtl/pmom_result_if.sv
rtl/pmom_cordic.sv
rtl/pmom_div.sv
rtl/perigee_to_four_momentum_top.sv
rtl/pmom_checker.sv
tb/sv/tb_perigee_to_four_momentum_top.sv
